### hdl/crmt_pkg.sv
// ----------------------------------------------------------------------------
// crmt_pkg
// Shared types and constants of the CAN receive mailbox table.
// ----------------------------------------------------------------------------
package crmt_pkg;

  // Number of mailboxes (1 .. 256)
  localparam int unsigned ENTRIES = 16;

  // Mailbox index and fill count widths
  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);

  localparam int unsigned ID_W   = 29;
  localparam int unsigned LEN_W  = 4;
  localparam int unsigned DATA_W = 64;
  localparam int unsigned STAT_W = 2;

  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(8);

  // Stream widths, padded to whole bytes
  localparam int unsigned IN_FIELDS_W  = ID_W + LEN_W + DATA_W;
  localparam int unsigned IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int unsigned OUT_FIELDS_W = STAT_W + LEN_W + DATA_W;
  localparam int unsigned OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Operation selector carried in tuser
  localparam logic FUNC_STORE = 1'b0;
  localparam logic FUNC_READ  = 1'b1;

  typedef logic [STAT_W-1:0] status_t;

  // Store results
  localparam status_t STAT_UPDATED  = 2'd0;
  localparam status_t STAT_ADDED    = 2'd1;
  localparam status_t STAT_DROPPED  = 2'd2;
  // Read results
  localparam status_t STAT_FRESH    = 2'd0;
  localparam status_t STAT_REPEATED = 2'd1;
  localparam status_t STAT_UNKNOWN  = 2'd2;

  // One mailbox payload word
  typedef struct packed {
    logic              fresh;
    logic [LEN_W-1:0]  length;
    logic [DATA_W-1:0] data;
  } payload_t;

  localparam int unsigned PAY_W = $bits(payload_t);

endpackage

### hdl/crmt_ram.sv
// ----------------------------------------------------------------------------
// crmt_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module crmt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                           wdata_i,
  input  logic                                       re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/can_receive_mailbox_table.sv
// ----------------------------------------------------------------------------
// can_receive_mailbox_table
// Sequence: an item scans identifiers from mailbox 0 up to the hit or the last
//   live mailbox (no scan on an empty table), then ST_PAY or ST_MISS, then ST_FIN.
// Throughput: one item at a time, the next beat only once the result is loaded;
//   the pace is set by the linear identifier scan, one id RAM read per cycle.
// Reset: asynchronous, active low; clears the fill count and handshake state.
//   The RAMs need no clearing pass: mailboxes past the fill count are unused.
// ----------------------------------------------------------------------------
// Mailboxes fill from index 0 upward and are only freed by reset, so the fill
// count alone tells which RAM words hold live entries. Identifiers sit in one
// RAM, fresh flag, length and data in a second; both are written together
// when a mailbox is added.
// ----------------------------------------------------------------------------
module can_receive_mailbox_table (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // input stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // tdata: msg_id[28:0], frame_length[32:29], frame_data[96:33], zero pad
  input  logic [crmt_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // tuser: func (0 store, 1 read)
  input  logic                              s_axis_tuser,
  // result stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // tdata: status[1:0], out_length[5:2], out_data[69:6], zero pad
  output logic [crmt_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

  localparam int unsigned IDX_W  = crmt_pkg::IDX_W;
  localparam int unsigned CNT_W  = crmt_pkg::CNT_W;
  localparam int unsigned ID_W   = crmt_pkg::ID_W;
  localparam int unsigned LEN_W  = crmt_pkg::LEN_W;
  localparam int unsigned DATA_W = crmt_pkg::DATA_W;

  // Sequencer states, one-hot
  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,  // waiting for a beat
    ST_SCAN = 5'b00010,  // comparing identifiers, one per cycle
    ST_PAY  = 5'b00100,  // payload of the hit read, modify and write back
    ST_MISS = 5'b01000,  // no hit: add a mailbox or report
    ST_FIN  = 5'b10000   // result waits for a free output register
  } state_e;

  state_e state_q, state_d;

  // Latched item
  logic              func_q, func_d;
  logic [ID_W-1:0]   id_q, id_d;
  logic [LEN_W-1:0]  len_q, len_d;
  logic [DATA_W-1:0] data_q, data_d;

  // Scan position: index whose id RAM word arrives this cycle
  logic [IDX_W-1:0]  rd_idx_q, rd_idx_d;
  logic [CNT_W-1:0]  used_q, used_d;

  // Pending result
  crmt_pkg::status_t res_status_q, res_status_d;
  logic [LEN_W-1:0]  res_len_q, res_len_d;
  logic [DATA_W-1:0] res_data_q, res_data_d;

  // Output register
  logic                             out_valid_q, out_valid_d;
  logic [crmt_pkg::OUT_TDATA_W-1:0] out_tdata_q, out_tdata_d;

  // RAM ports
  logic              id_we, id_re;
  logic [IDX_W-1:0]  id_waddr, id_raddr;
  logic [ID_W-1:0]   id_rdata;
  logic              pay_we, pay_re;
  logic [IDX_W-1:0]  pay_waddr, pay_raddr;
  crmt_pkg::payload_t pay_wdata, pay_rdata;

  logic              in_beat;
  logic              out_load;
  logic [LEN_W-1:0]  in_len;

  assign in_beat       = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_len        = s_axis_tdata[ID_W +: LEN_W];
  assign out_load      = (state_q == ST_FIN) && (!out_valid_q || m_axis_tready);

  always_comb begin
    state_d      = state_q;
    func_d       = func_q;
    id_d         = id_q;
    len_d        = len_q;
    data_d       = data_q;
    rd_idx_d     = rd_idx_q;
    used_d       = used_q;
    res_status_d = res_status_q;
    res_len_d    = res_len_q;
    res_data_d   = res_data_q;

    id_we     = 1'b0;
    id_waddr  = used_q[IDX_W-1:0];
    id_re     = 1'b0;
    id_raddr  = '0;
    pay_we    = 1'b0;
    pay_waddr = rd_idx_q;
    pay_wdata = '{fresh: 1'b1, length: len_q, data: data_q};
    pay_re    = 1'b0;
    pay_raddr = rd_idx_q;

    case (state_q)
      ST_IDLE: begin
        if (in_beat) begin
          func_d   = s_axis_tuser;
          id_d     = s_axis_tdata[ID_W-1:0];
          // lengths above eight saturate
          len_d    = (in_len > crmt_pkg::MAX_LEN) ? crmt_pkg::MAX_LEN : in_len;
          data_d   = s_axis_tdata[ID_W+LEN_W +: DATA_W];
          rd_idx_d = '0;
          if (used_q == '0) begin
            state_d = ST_MISS;
          end else begin
            id_re   = 1'b1;
            state_d = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        if (id_rdata == id_q) begin
          pay_re  = 1'b1;
          state_d = ST_PAY;
        end else if (CNT_W'(rd_idx_q) + CNT_W'(1) == used_q) begin
          state_d = ST_MISS;
        end else begin
          id_re    = 1'b1;
          id_raddr = rd_idx_q + IDX_W'(1);
          rd_idx_d = rd_idx_q + IDX_W'(1);
        end
      end

      ST_PAY: begin
        pay_we = 1'b1;
        if (func_q == crmt_pkg::FUNC_STORE) begin
          res_status_d = crmt_pkg::STAT_UPDATED;
          res_len_d    = '0;
          res_data_d   = '0;
        end else begin
          // read clears the new-data flag
          pay_wdata    = '{fresh: 1'b0, length: pay_rdata.length, data: pay_rdata.data};
          res_status_d = pay_rdata.fresh ? crmt_pkg::STAT_FRESH : crmt_pkg::STAT_REPEATED;
          res_len_d    = pay_rdata.length;
          res_data_d   = pay_rdata.data;
        end
        state_d = ST_FIN;
      end

      ST_MISS: begin
        res_len_d  = '0;
        res_data_d = '0;
        if (func_q == crmt_pkg::FUNC_STORE) begin
          if (used_q < CNT_W'(crmt_pkg::ENTRIES)) begin
            id_we        = 1'b1;
            pay_we       = 1'b1;
            pay_waddr    = used_q[IDX_W-1:0];
            used_d       = used_q + CNT_W'(1);
            res_status_d = crmt_pkg::STAT_ADDED;
          end else begin
            res_status_d = crmt_pkg::STAT_DROPPED;
          end
        end else begin
          res_status_d = crmt_pkg::STAT_UNKNOWN;
        end
        state_d = ST_FIN;
      end

      ST_FIN: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output register: free once the beat leaves, reloaded from the result
  always_comb begin
    out_valid_d = out_valid_q;
    out_tdata_d = out_tdata_q;
    if (m_axis_tvalid && m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
      out_tdata_d = crmt_pkg::OUT_TDATA_W'({res_data_q, res_len_q, res_status_q});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      used_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q       <= func_d;
    id_q         <= id_d;
    len_q        <= len_d;
    data_q       <= data_d;
    rd_idx_q     <= rd_idx_d;
    res_status_q <= res_status_d;
    res_len_q    <= res_len_d;
    res_data_q   <= res_data_d;
    out_tdata_q  <= out_tdata_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_tdata_q;

  crmt_ram #(
    .WIDTH (ID_W),
    .DEPTH (crmt_pkg::ENTRIES)
  ) u_id_ram (
    .clk_i   (clk_i),
    .we_i    (id_we),
    .waddr_i (id_waddr),
    .wdata_i (id_q),
    .re_i    (id_re),
    .raddr_i (id_raddr),
    .rdata_o (id_rdata)
  );

  crmt_ram #(
    .WIDTH (crmt_pkg::PAY_W),
    .DEPTH (crmt_pkg::ENTRIES)
  ) u_pay_ram (
    .clk_i   (clk_i),
    .we_i    (pay_we),
    .waddr_i (pay_waddr),
    .wdata_i (pay_wdata),
    .re_i    (pay_re),
    .raddr_i (pay_raddr),
    .rdata_o (pay_rdata)
  );

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CNT_W'(crmt_pkg::ENTRIES))
    else $error("fill count beyond table size");

  a_scan_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (CNT_W'(rd_idx_q) < used_q))
    else $error("scan past the last live mailbox");

  a_add_both: assert property (@(posedge clk_i) disable iff (!rst_ni)
    id_we |-> (pay_we && pay_waddr == id_waddr))
    else $error("mailbox added without its payload");

  a_used_only_on_add: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_MISS) |=> $stable(used_q))
    else $error("fill count moved outside an add");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready) |-> !out_load)
    else $error("result overwrote a waiting beat");

endmodule

### bench/can_receive_mailbox_table_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// can_receive_mailbox_table_tb
// Self-checking bench for the CAN receive mailbox table. A local mailbox
// model predicts status, length and data for every accepted request beat, and
// each result beat is compared against the oldest prediction. Directed tests
// cover the empty table, the store/read cycle, length saturation and a full
// table; random traffic then runs under several sender and receiver idling
// mixes.
// ----------------------------------------------------------------------------
module can_receive_mailbox_table_tb;
  import crmt_pkg::*;

  localparam int unsigned QUIET_LIMIT  = 5000;  // cycles with no beat moved
  localparam int unsigned RANDOM_BEATS = 420;   // per idling mix
  localparam logic [ID_W-1:0]   ID_MAX   = '1;
  localparam logic [DATA_W-1:0] DATA_MAX = '1;

  // One predicted or observed result, in field order
  typedef struct packed {
    status_t           status;
    logic [LEN_W-1:0]  length;
    logic [DATA_W-1:0] data;
  } mailbox_result_t;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   s_axis_tuser  = FUNC_STORE;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  // Mailbox model state
  logic              mb_valid  [ENTRIES];
  logic [ID_W-1:0]   mb_id     [ENTRIES];
  logic              mb_fresh  [ENTRIES];
  logic [LEN_W-1:0]  mb_length [ENTRIES];
  logic [DATA_W-1:0] mb_data   [ENTRIES];
  int unsigned       mb_used;

  // Identifiers that own a mailbox, filled in by the directed tests
  logic [ID_W-1:0]   known_ids [ENTRIES];
  int unsigned       known_count;

  mailbox_result_t   pending_results[$];
  int unsigned       tx_idle_pct  = 0;
  int unsigned       rx_stall_pct = 0;
  int unsigned       mismatches   = 0;
  int unsigned       quiet_cycles = 0;

  can_receive_mailbox_table dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic void clear_mailboxes();
    for (int i = 0; i < ENTRIES; i++) begin
      mb_valid[i]  = 1'b0;
      mb_id[i]     = '0;
      mb_fresh[i]  = 1'b0;
      mb_length[i] = '0;
      mb_data[i]   = '0;
    end
    mb_used     = 0;
    known_count = 0;
  endfunction

  // Applies one request to the model and returns the result it should give.
  function automatic mailbox_result_t predict_mailbox_result(
      input logic func, input logic [ID_W-1:0] id,
      input logic [LEN_W-1:0] len, input logic [DATA_W-1:0] data);
    mailbox_result_t  res;
    int               hit;
    logic [LEN_W-1:0] sat_len;
    res     = '{status: STAT_UNKNOWN, length: '0, data: '0};
    hit     = -1;
    sat_len = (len > MAX_LEN) ? MAX_LEN : len;
    for (int i = 0; i < ENTRIES; i++)
      if (hit < 0 && mb_valid[i] && mb_id[i] == id) hit = i;
    if (func == FUNC_STORE) begin
      // store results never carry payload
      if (hit >= 0) begin
        res.status = STAT_UPDATED;
      end else if (mb_used < ENTRIES) begin
        hit           = int'(mb_used);
        mb_used++;
        mb_valid[hit] = 1'b1;
        mb_id[hit]    = id;
        res.status    = STAT_ADDED;
      end else begin
        res.status = STAT_DROPPED;
      end
      if (hit >= 0) begin
        mb_length[hit] = sat_len;
        mb_data[hit]   = data;
        mb_fresh[hit]  = 1'b1;
      end
    end else if (hit >= 0) begin
      res.status    = mb_fresh[hit] ? STAT_FRESH : STAT_REPEATED;
      res.length    = mb_length[hit];
      res.data      = mb_data[hit];
      mb_fresh[hit] = 1'b0;
    end
    return res;
  endfunction

  // Picks an identifier that has no mailbox yet (and is neither extreme).
  function automatic logic [ID_W-1:0] unused_id();
    logic [ID_W-1:0] id;
    logic            clash;
    do begin
      id    = ID_W'($urandom);
      clash = (id == '0) || (id == ID_MAX);
      for (int i = 0; i < known_count; i++)
        if (known_ids[i] == id) clash = 1'b1;
    end while (clash);
    return id;
  endfunction

  // Presents one request beat, waits for acceptance, records the prediction.
  // Valid is left high after acceptance so back-to-back beats need no dip.
  task automatic send_request(input logic func, input logic [ID_W-1:0] id,
                              input logic [LEN_W-1:0] len,
                              input logic [DATA_W-1:0] data);
    mailbox_result_t want;
    while ($urandom_range(99, 0) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= func;
    s_axis_tdata  <= IN_TDATA_W'({data, len, id});
    do @(posedge clk_i); while (!s_axis_tready);
    want = predict_mailbox_result(func, id, len, data);
    pending_results.insert(pending_results.size(), want);
  endtask

  // Sender holds off until every outstanding result has come back.
  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic store_new_id(input logic [ID_W-1:0] id,
                              input logic [LEN_W-1:0] len,
                              input logic [DATA_W-1:0] data);
    known_ids[known_count] = id;
    known_count++;
    send_request(FUNC_STORE, id, len, data);
  endtask

  // Lookups on an empty table
  task automatic test_empty_lookup();
    send_request(FUNC_READ, '0, '0, '0);
    send_request(FUNC_READ, ID_MAX, '1, DATA_MAX);
    wait_for_results();
  endtask

  // Add, read fresh, read repeated, update, data past the length kept
  task automatic test_store_read_cycle();
    store_new_id('0, '0, DATA_MAX);
    store_new_id(ID_MAX, LEN_W'(8), '0);
    send_request(FUNC_READ, ID_MAX, '0, '0);
    send_request(FUNC_READ, ID_MAX, '0, '0);
    send_request(FUNC_STORE, '0, LEN_W'(3), 64'h0123_4567_89ab_cdef);
    send_request(FUNC_READ, '0, '1, DATA_MAX);
    wait_for_results();
  endtask

  // Lengths above eight saturate
  task automatic test_length_saturation();
    send_request(FUNC_STORE, ID_MAX, '1, 64'hfedc_ba98_7654_3210);
    send_request(FUNC_STORE, ID_MAX, LEN_W'(9), DATA_MAX);
    send_request(FUNC_READ, ID_MAX, '0, '0);
    wait_for_results();
  endtask

  // Fill every mailbox, then a new id is dropped, old ids still update
  task automatic test_fill_to_capacity();
    logic [ID_W-1:0] stray;
    while (known_count < ENTRIES)
      store_new_id(unused_id(), LEN_W'($urandom_range(8, 0)),
                   {$urandom, $urandom});
    stray = unused_id();
    send_request(FUNC_STORE, stray, LEN_W'(5), {$urandom, $urandom});
    send_request(FUNC_READ, stray, '0, '0);
    send_request(FUNC_STORE, known_ids[ENTRIES-1], LEN_W'(1), DATA_MAX);
    send_request(FUNC_READ, known_ids[ENTRIES-1], '0, '0);
    wait_for_results();
  endtask

  // Random stores and reads, mostly on owned identifiers
  task automatic test_mixed_traffic(input int unsigned beats,
                                    input int unsigned idle_pct,
                                    input int unsigned stall_pct);
    logic              func;
    logic [ID_W-1:0]   id;
    logic [LEN_W-1:0]  len;
    logic [DATA_W-1:0] data;
    tx_idle_pct  = idle_pct;
    rx_stall_pct = stall_pct;
    for (int n = 0; n < beats; n++) begin
      func = ($urandom_range(1, 0) == 1) ? FUNC_READ : FUNC_STORE;
      if (known_count != 0 && $urandom_range(99, 0) < 75)
        id = known_ids[$urandom_range(known_count - 1, 0)];
      else
        id = ID_W'($urandom);
      len  = ($urandom_range(99, 0) < 85) ? LEN_W'($urandom_range(8, 0))
                                          : LEN_W'($urandom_range(15, 9));
      data = {$urandom, $urandom};
      send_request(func, id, len, data);
    end
    wait_for_results();
  endtask

  // Receiver side: random tready, result check, quiet-cycle count
  always @(posedge clk_i) begin
    mailbox_result_t got;
    mailbox_result_t want;
    m_axis_tready <= ($urandom_range(99, 0) >= rx_stall_pct);
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) ||
        (m_axis_tvalid && m_axis_tready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.status = m_axis_tdata[STAT_W-1:0];
      got.length = m_axis_tdata[STAT_W +: LEN_W];
      got.data   = m_axis_tdata[STAT_W+LEN_W +: DATA_W];
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected beat: expected none, got status %0d len %0d data %h",
                 $time, got.status, got.length, got.data);
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status || got.length !== want.length ||
            got.data !== want.data) begin
          mismatches++;
          $display("%0t: expected status %0d len %0d data %h, got %0d len %0d data %h",
                   $time, want.status, want.length, want.data,
                   got.status, got.length, got.data);
        end
      end
    end
  end

  // Watchdog: ends the run if no beat moves for too long
  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk_i);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    clear_mailboxes();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_lookup();
    test_store_read_cycle();
    test_length_saturation();
    test_fill_to_capacity();
    test_mixed_traffic(RANDOM_BEATS, 0, 0);
    test_mixed_traffic(RANDOM_BEATS, 48, 0);
    test_mixed_traffic(RANDOM_BEATS, 0, 48);
    test_mixed_traffic(RANDOM_BEATS, 25, 25);
    // let any stray beat surface before the verdict
    repeat (ENTRIES + 8) @(posedge clk_i);
    if (mismatches == 0 && pending_results.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
